FILE: rtl/core/pdpg_pkg.sv
// Shared types and constants of the dashed polyline pattern generator.
package pdpg_pkg;

  localparam int DefCoordBits = 8;
  localparam int DefMaxDashes = 64;

  localparam int DashW   = 12;
  localparam int IdxW    = 12;
  localparam int PhaseW  = 13;
  localparam int CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] RegDashLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGapLength  = CfgIdxW'(1);

  localparam logic [DashW-1:0] DashReset = DashW'(60);
  localparam logic [DashW-1:0] GapReset  = DashW'(40);
  localparam logic [IdxW-1:0]  IdxMax    = {IdxW{1'b1}};

  localparam int SeedMulX    = 31;
  localparam int SeedMulY    = 47;
  localparam int SeedMulEndX = 61;
  localparam int SeedMulEndY = 89;

  localparam int DiagWeight     = 14;
  localparam int StraightWeight = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_SEED,
    ST_DIV_PHASE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic set_phase;
    logic walk_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic path_start;
    logic have_prev;
    logic skip;
    logic phase_in_range;
    logic div_done;
    logic walk_end;
    logic step_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/pdpg_if.sv
// Handshake interfaces for point words, dash words and configuration words.
interface pdpg_pnt_if #(
  parameter int COORD_BITS = pdpg_pkg::DefCoordBits
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic                  path_start;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, x, y, path_start, end_x, end_y, input ready);
  modport sink (input valid, x, y, path_start, end_x, end_y, output ready);
endinterface

interface pdpg_dash_if;
  logic                         valid;
  logic                         ready;
  logic [pdpg_pkg::IdxW-1:0]    segment_index;
  logic [pdpg_pkg::DashW-1:0]   dash_start;
  logic [pdpg_pkg::DashW-1:0]   dash_end;
  logic [pdpg_pkg::DashW-1:0]   segment_length;
  logic                         last;
  logic                         truncated;

  modport source (output valid, segment_index, dash_start, dash_end, segment_length, last,
                  truncated, input ready);
  modport sink (input valid, segment_index, dash_start, dash_end, segment_length, last,
                truncated, output ready);
endinterface

interface pdpg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pdpg_pkg::CfgIdxW-1:0]  index;
  logic [pdpg_pkg::DashW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pdpg_ctrl.sv
// Controller state machine sequencing path starts, phase reduction and the dash walk.
module pdpg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pdpg_pkg::sts_t         sts_i,
  output pdpg_pkg::cmd_t         cmd_o,
  output pdpg_pkg::state_e       state_o
);

  pdpg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdpg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pdpg_pkg::ST_PREP;
      end
      pdpg_pkg::ST_PREP: begin
        if (sts_i.path_start) begin
          state_d = pdpg_pkg::ST_DIV_SEED;
        end else if (!sts_i.have_prev || sts_i.skip) begin
          state_d = pdpg_pkg::ST_IDLE;
        end else if (sts_i.phase_in_range) begin
          state_d = pdpg_pkg::ST_WALK;
        end else begin
          state_d = pdpg_pkg::ST_DIV_PHASE;
        end
      end
      pdpg_pkg::ST_DIV_SEED: begin
        if (sts_i.div_done) state_d = pdpg_pkg::ST_IDLE;
      end
      pdpg_pkg::ST_DIV_PHASE: begin
        if (sts_i.div_done) state_d = pdpg_pkg::ST_WALK;
      end
      pdpg_pkg::ST_WALK: begin
        if (sts_i.walk_end) begin
          state_d = sts_i.pend_valid ? pdpg_pkg::ST_FLUSH : pdpg_pkg::ST_IDLE;
        end
      end
      pdpg_pkg::ST_FLUSH: begin
        if (sts_i.out_free) state_d = pdpg_pkg::ST_IDLE;
      end
      default: state_d = pdpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q) inside
      pdpg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pdpg_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      pdpg_pkg::ST_DIV_SEED, pdpg_pkg::ST_DIV_PHASE: begin
        cmd_o.div_step  = !sts_i.div_done;
        cmd_o.set_phase = sts_i.div_done;
      end
      pdpg_pkg::ST_WALK: begin
        cmd_o.walk_step = !sts_i.walk_end && sts_i.step_ok;
      end
      pdpg_pkg::ST_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: rtl/core/pdpg_dpath.sv
// Datapath: point registers, seed and octile length, shared divider, dash walk and output word.
module pdpg_dpath #(
  parameter int COORD_BITS = pdpg_pkg::DefCoordBits,
  parameter int MAX_DASHES = pdpg_pkg::DefMaxDashes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdpg_pkg::cmd_t                cmd_i,
  output pdpg_pkg::sts_t                sts_o,
  input  logic [pdpg_pkg::DashW-1:0]    dash_len_i,
  input  logic [pdpg_pkg::DashW-1:0]    gap_len_i,
  input  logic [COORD_BITS-1:0]         x_i,
  input  logic [COORD_BITS-1:0]         y_i,
  input  logic                          path_start_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pdpg_pkg::IdxW-1:0]     segment_index_o,
  output logic [pdpg_pkg::DashW-1:0]    dash_start_o,
  output logic [pdpg_pkg::DashW-1:0]    dash_end_o,
  output logic [pdpg_pkg::DashW-1:0]    segment_length_o,
  output logic                          last_o,
  output logic                          truncated_o
);

  localparam int C       = COORD_BITS;
  localparam int LenW    = C + 4;
  localparam int SeedW   = C + 8;
  localparam int PW      = pdpg_pkg::PhaseW;
  localparam int DW      = pdpg_pkg::DashW;
  localparam int DivW    = (SeedW > PW) ? SeedW : PW;
  localparam int DivCntW = $clog2(DivW + 1);
  localparam int TakeW   = (LenW > PW) ? LenW : PW;
  localparam int NW      = $clog2(MAX_DASHES + 1);

  // Accepted point word.
  logic [C-1:0] x_q, y_q, ex_q, ey_q;
  logic         start_q;

  // Path state.
  logic [C-1:0]                 prev_x_q, prev_y_q;
  logic [PW-1:0]                phase_q, phase_d;
  logic [pdpg_pkg::IdxW-1:0]    count_q;
  logic                         have_q;

  // Divider.
  logic [DivW-1:0]    dvd_q;
  logic [PW-1:0]      rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [PW:0]        rem_sh;
  logic [PW:0]        rem_nx;

  // Walk.
  logic [LenW-1:0] len_q, pos_q;
  logic [NW-1:0]   n_q;
  logic            trunc_q;
  logic            pend_v_q;
  logic [DW-1:0]   pend_start_q, pend_end_q;

  // Output word.
  logic                      out_v_q;
  logic [pdpg_pkg::IdxW-1:0] o_idx_q;
  logic [DW-1:0]             o_start_q, o_end_q, o_len_q;
  logic                      o_last_q, o_trunc_q;

  logic [PW-1:0]    period;
  logic [SeedW-1:0] seed_c;
  logic [C-1:0]     dx, dy, lo, hi;
  logic [LenW-1:0]  len_c;
  logic             in_dash;
  logic [PW-1:0]    remain;
  logic [LenW-1:0]  left;
  logic [TakeW-1:0] take;
  logic [LenW-1:0]  pos_nx;
  logic [PW-1:0]    ph_sum;
  logic [PW-1:0]    ph_nx;
  logic             emit;
  logic             out_free;
  logic             push;

  assign period = PW'(dash_len_i) + PW'(gap_len_i);

  assign seed_c = SeedW'(x_q) * SeedW'(pdpg_pkg::SeedMulX)
                + SeedW'(y_q) * SeedW'(pdpg_pkg::SeedMulY)
                + SeedW'(ex_q) * SeedW'(pdpg_pkg::SeedMulEndX)
                + SeedW'(ey_q) * SeedW'(pdpg_pkg::SeedMulEndY);

  assign dx    = (x_q >= prev_x_q) ? x_q - prev_x_q : prev_x_q - x_q;
  assign dy    = (y_q >= prev_y_q) ? y_q - prev_y_q : prev_y_q - y_q;
  assign lo    = (dx < dy) ? dx : dy;
  assign hi    = (dx < dy) ? dy : dx;
  assign len_c = LenW'(lo) * LenW'(pdpg_pkg::DiagWeight)
               + LenW'(hi - lo) * LenW'(pdpg_pkg::StraightWeight);

  // One restoring step of the remainder by the pattern period.
  assign rem_sh = {rem_q, dvd_q[DivW-1]};
  assign rem_nx = (rem_sh >= {1'b0, period}) ? rem_sh - {1'b0, period} : rem_sh;

  assign in_dash = phase_q < PW'(dash_len_i);
  assign remain  = in_dash ? PW'(dash_len_i) - phase_q : period - phase_q;
  assign left    = len_q - pos_q;
  assign take    = (TakeW'(remain) < TakeW'(left)) ? TakeW'(remain) : TakeW'(left);
  assign pos_nx  = pos_q + LenW'(take);
  assign ph_sum  = phase_q + PW'(take);
  assign ph_nx   = (ph_sum >= period) ? '0 : ph_sum;
  assign emit    = in_dash && (n_q < NW'(MAX_DASHES));

  assign out_free = !out_v_q || out_ready_i;
  assign push     = (cmd_i.walk_step && emit && pend_v_q) || cmd_i.flush;

  always_comb begin
    sts_o.path_start     = start_q;
    sts_o.have_prev      = have_q;
    sts_o.skip           = (len_c == '0) || (dash_len_i == '0);
    sts_o.phase_in_range = phase_q < period;
    sts_o.div_done       = div_cnt_q == DivCntW'(DivW);
    sts_o.walk_end       = pos_q >= len_q;
    sts_o.step_ok        = !(emit && pend_v_q) || out_free;
    sts_o.pend_valid     = pend_v_q;
    sts_o.out_free       = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_i;
      y_q     <= y_i;
      start_q <= path_start_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (cmd_i.set_phase) begin
      phase_d = (period == '0) ? '0 : rem_q;
    end else if (cmd_i.walk_step) begin
      phase_d = ph_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      phase_q  <= '0;
      count_q  <= '0;
      have_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (cmd_i.prep) begin
        prev_x_q <= x_q;
        prev_y_q <= y_q;
        have_q   <= 1'b1;
        if (start_q || !have_q) begin
          count_q <= '0;
        end else if (count_q != pdpg_pkg::IdxMax) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dvd_q <= start_q ? DivW'(seed_c) : DivW'(phase_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      rem_q <= rem_nx[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.prep) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      trunc_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (cmd_i.prep) begin
      n_q      <= '0;
      trunc_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      if (emit) begin
        n_q      <= n_q + 1'b1;
        pend_v_q <= 1'b1;
      end else if (in_dash) begin
        trunc_q <= 1'b1;
      end
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      len_q <= len_c;
      pos_q <= '0;
    end else if (cmd_i.walk_step) begin
      pos_q <= pos_nx;
      if (emit) begin
        pend_start_q <= DW'(pos_q);
        pend_end_q   <= DW'(pos_nx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      o_idx_q   <= count_q;
      o_start_q <= pend_start_q;
      o_end_q   <= pend_end_q;
      o_len_q   <= DW'(len_q);
      o_last_q  <= cmd_i.flush;
      o_trunc_q <= cmd_i.flush && trunc_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign segment_index_o  = o_idx_q;
  assign dash_start_o     = o_start_q;
  assign dash_end_o       = o_end_q;
  assign segment_length_o = o_len_q;
  assign last_o           = o_last_q;
  assign truncated_o      = o_trunc_q;

endmodule

FILE: rtl/core/polyline_dash_pattern_generator_top.sv
// Top level of the dashed polyline pattern generator: registers, controller and datapath.
// A path-start point passes through preparation and the bit-serial divider, which reduces
// its seed by the pattern period. A segment point passes through preparation, a phase
// reduction if needed, one walk step per dash or gap piece and a flush of any final dash word.
// The walk stalls only when a dash word is waiting and the output word is not taken.
// Reset clears the path state, sets dash and gap lengths to 60 and 40, and needs no sweep.
module polyline_dash_pattern_generator_top #(
  parameter int COORD_BITS             = pdpg_pkg::DefCoordBits,
  parameter int MAX_DASHES_PER_SEGMENT = pdpg_pkg::DefMaxDashes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdpg_pnt_if.sink    pnt_i,
  pdpg_dash_if.source dash_o,
  pdpg_cfg_if.sink    cfg_i
);

  logic [pdpg_pkg::DashW-1:0] dash_len_q, gap_len_q;
  pdpg_pkg::cmd_t             cmd;
  pdpg_pkg::sts_t             sts;
  pdpg_pkg::state_e           state;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_len_q <= pdpg_pkg::DashReset;
      gap_len_q  <= pdpg_pkg::GapReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pdpg_pkg::RegDashLength: dash_len_q <= cfg_i.data;
        pdpg_pkg::RegGapLength:  gap_len_q  <= cfg_i.data;
        default: begin
          dash_len_q <= dash_len_q;
        end
      endcase
    end
  end

  pdpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pnt_i.valid),
    .in_ready_o (pnt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  pdpg_dpath #(
    .COORD_BITS (COORD_BITS),
    .MAX_DASHES (MAX_DASHES_PER_SEGMENT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .dash_len_i       (dash_len_q),
    .gap_len_i        (gap_len_q),
    .x_i              (pnt_i.x),
    .y_i              (pnt_i.y),
    .path_start_i     (pnt_i.path_start),
    .end_x_i          (pnt_i.end_x),
    .end_y_i          (pnt_i.end_y),
    .out_valid_o      (dash_o.valid),
    .out_ready_i      (dash_o.ready),
    .segment_index_o  (dash_o.segment_index),
    .dash_start_o     (dash_o.dash_start),
    .dash_end_o       (dash_o.dash_end),
    .segment_length_o (dash_o.segment_length),
    .last_o           (dash_o.last),
    .truncated_o      (dash_o.truncated)
  );

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_i.valid && pnt_i.ready |=> !pnt_i.ready)
    else $error("point word accepted while the previous one was still in progress");

  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dash_o.valid && dash_o.truncated |-> dash_o.last)
    else $error("truncation flag on a dash word that is not the last");

  a_walk_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == pdpg_pkg::ST_WALK && sts.walk_end && !sts.pend_valid
    |=> state == pdpg_pkg::ST_IDLE)
    else $error("walk ended without dashes but controller did not return to idle");

  a_flush_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> (!dash_o.valid || dash_o.ready))
    else $error("final dash word pushed over an untaken word");

endmodule
